[rtl/sorted_unique_set_table_assert.svh]
// Assertion macros used by the checker file of the sorted set table.
`ifndef SORTED_UNIQUE_SET_TABLE_ASSERT_SVH
`define SORTED_UNIQUE_SET_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define SUST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define SUST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sust_pkg.sv]
// Package: sizes, codes, state type and cell control struct of the sorted set table.
package sust_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int VAL_W    = 32;
    localparam int RANK_W   = 6;
    localparam int FUNC_W   = 2;
    localparam int STAT_W   = 3;
    localparam int COUNT_W  = 7;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

[rtl/sust_cell.sv]
// One table cell: holds an entry, compares it with the operand, shifts with its neighbors.
module sust_cell
    import sust_pkg::*;
(
    input  logic                    aclk,
    input  cell_ctrl_t              ctrl,
    input  logic                    occupied,
    input  logic                    at_or_after_rank,
    input  logic signed [VAL_W-1:0] new_value,
    input  logic                    left_lt,
    input  logic signed [VAL_W-1:0] left_value,
    input  logic signed [VAL_W-1:0] right_value,
    output logic signed [VAL_W-1:0] value_q,
    output logic                    lt_q,
    output logic                    eq_q
);

    logic signed [VAL_W-1:0] value_reg;
    logic                    lt_reg;
    logic                    eq_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            lt_reg <= occupied && (value_reg < new_value);
            eq_reg <= occupied && (value_reg == new_value);
        end
    end

    // Insert: first cell not below the operand takes it, cells past it take the left word.
    // Remove: cells from the rank on take the right word.
    always_ff @(posedge aclk) begin
        if (ctrl.ins_en && !lt_reg) begin
            value_reg <= left_lt ? new_value : left_value;
        end else if (ctrl.rem_en && at_or_after_rank) begin
            value_reg <= right_value;
        end
    end

    assign value_q = value_reg;
    assign lt_q    = lt_reg;
    assign eq_q    = eq_reg;

endmodule

[rtl/sorted_unique_set_table.sv]
// Top level: sorted set table built from a row of compare-and-shift cells.
//
//  channel   dir   payload (lsb first)                         accept
//  s_axis    in    func[1:0] value[33:2] rank[39:34]           tvalid & tready
//  m_axis    out   read_value[31:0] status[34:32] count[41:35]  tvalid & tready
//
// Each word passes through accept, compare in every cell, then shift and result.
// The compare and the shift of all cells run in parallel, so the time does not
// depend on the fill level. A new word is taken while a result still waits.
// The apply step holds while the output register is full and not taken.
// Synchronous active-low reset empties the table; entry contents are left as is.
module sorted_unique_set_table
    import sust_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // func[1:0], value[33:2], rank[39:34]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // read_value[31:0], status[34:32],
                                                // count[41:35], zero[47:42]
);

    state_t state_reg, state_next;

    logic [FUNC_W-1:0]       func_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic [RANK_W-1:0]       rank_reg;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic                    m_valid_reg;
    logic signed [VAL_W-1:0] m_value_reg, m_value_next;
    logic [STAT_W-1:0]       m_status_reg, m_status_next;

    logic in_fire;
    logic cmp_en;
    logic apply_go;

    logic signed [VAL_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]     cell_lt;
    logic [CAPACITY-1:0]     cell_eq;
    logic [CAPACITY-1:0]     occupied;
    logic [CAPACITY-1:0]     from_rank;

    logic dup;
    logic full;
    logic rank_ok;
    logic ins_do;
    logic rem_do;
    cell_ctrl_t ctrl;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_CMP;
            S_CMP:   state_next = S_APPLY;
            S_APPLY: if (apply_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        cmp_en        = 1'b0;
        apply_go      = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_axis_tready = 1'b1;
            S_CMP:   cmp_en = 1'b1;
            S_APPLY: apply_go = !m_valid_reg || m_axis_tready;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            func_reg  <= s_axis_tdata[1:0];
            value_reg <= s_axis_tdata[33:2];
            rank_reg  <= s_axis_tdata[39:34];
        end
    end

    assign dup     = |(cell_eq & occupied);
    assign full    = int'(count_reg) >= CAPACITY;
    assign rank_ok = int'(rank_reg) < int'(count_reg);
    assign ins_do  = (func_reg == FN_INSERT) && !dup && !full;
    assign rem_do  = (func_reg == FN_REMOVE) && rank_ok;

    assign ctrl.cmp_en = cmp_en;
    assign ctrl.ins_en = apply_go && ins_do;
    assign ctrl.rem_en = apply_go && rem_do;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                    left_lt;
            logic signed [VAL_W-1:0] left_value;
            logic signed [VAL_W-1:0] right_value;

            assign occupied[gi]  = int'(count_reg) > gi;
            assign from_rank[gi] = int'(rank_reg) <= gi;

            if (gi == 0) begin : g_first
                assign left_lt    = 1'b1;
                assign left_value = value_reg;
            end else begin : g_inner
                assign left_lt    = cell_lt[gi-1];
                assign left_value = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_value = cell_value[gi];
            end else begin : g_body
                assign right_value = cell_value[gi+1];
            end

            sust_cell u_cell (
                .aclk             (aclk),
                .ctrl             (ctrl),
                .occupied         (occupied[gi]),
                .at_or_after_rank (from_rank[gi]),
                .new_value        (value_reg),
                .left_lt          (left_lt),
                .left_value       (left_value),
                .right_value      (right_value),
                .value_q          (cell_value[gi]),
                .lt_q             (cell_lt[gi]),
                .eq_q             (cell_eq[gi])
            );
        end
    endgenerate

    // result and new count
    always_comb begin
        m_value_next  = '0;
        m_status_next = ST_OK;
        count_next    = count_reg;
        unique case (func_reg)
            FN_INSERT: begin
                if (dup) begin
                    m_status_next = ST_DUP;
                end else if (full) begin
                    m_status_next = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FN_READ, FN_REMOVE: begin
                if (count_reg == '0) begin
                    m_status_next = ST_EMPTY;
                end else if (!rank_ok) begin
                    m_status_next = ST_RANGE;
                end else if (func_reg == FN_READ) begin
                    m_value_next = cell_value[IDX_W'(rank_reg)];
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: m_status_next = ST_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (apply_go) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_go) begin
            m_value_reg  <= m_value_next;
            m_status_reg <= m_status_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, COUNT_W'(count_reg), m_status_reg, m_value_reg};

endmodule

[rtl/sust_checker.sv]
// Port-level checker for the sorted set table, bound to the top level.
`include "sorted_unique_set_table_assert.svh"

module sust_checker
    import sust_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [STAT_W-1:0]  st;
    logic [COUNT_W-1:0] cnt;

    assign st  = m_axis_tdata[34:32];
    assign cnt = m_axis_tdata[41:35];

    `SUST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
    `SUST_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "input taken while an operation is in flight")
    `SUST_ASSERT_NOW(a_count_cap, m_axis_tvalid,
        int'(cnt) <= CAPACITY, "count above capacity")
    `SUST_ASSERT_NOW(a_empty_zero, m_axis_tvalid && (st == ST_EMPTY),
        cnt == '0, "empty status with nonzero count")
    `SUST_ASSERT_NOW(a_value_ok, m_axis_tvalid && (m_axis_tdata[31:0] != '0),
        st == ST_OK, "read value on a failed operation")

endmodule

bind sorted_unique_set_table sust_checker u_sust_checker (.*);
